// ===== rtl/core/mtwg_pkg.sv =====
package mtwg_pkg;

   localparam int unsigned STATE_WORDS_DEF  = 624;
   localparam int unsigned TWIST_OFFSET_DEF = 397;

   localparam logic [31:0] SEED_MULT    = 32'd1812433253;
   localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
   localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

   typedef enum logic [2:0] {
      ST_SEED = 3'b001,
      ST_IDLE = 3'b010,
      ST_CALC = 3'b100
   } mtwg_state_type;

   // next seed word from the previous one (low 32 bits of the product)
   function automatic logic [31:0] mtwg_seed_next(input logic [31:0] prev,
                                                  input logic [31:0] index);
      logic [31:0] prod;
      prod = SEED_MULT * (prev ^ (prev >> 30));
      return prod + index;
   endfunction

   // new word k from old word k (top bit), word k+1 and word k+offset
   function automatic logic [31:0] mtwg_twist(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] far);
      logic [31:0] y;
      logic [31:0] v;
      y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
      v = far ^ (y >> 1);
      if (y[0]) begin
         v = v ^ TWIST_MATRIX;
      end
      return v;
   endfunction

   function automatic logic [31:0] mtwg_temper(input logic [31:0] y_in);
      logic [31:0] y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ===== rtl/core/mt19937_word_generator_core.sv =====
// Channel   Direction  Ports                          Payload
// req       in         req_tvalid/tready/tdata[7:0]   [0] reseed, [7:1] zero
// rsp       out        rsp_tvalid/tready/tdata[31:0]  [31:0] random_word
// csr       in         csr_valid/ready/data[31:0]     seed_value
//
// In a draw, the accept cycle issues both reads of the state
// memory (word k+1 and word k+offset), then the calc state twists word k,
// writes it back and loads the tempered word into the output register.
// A reseed first runs a seed pass: one word per cycle through the seed multiplier.
// After reset the state is seeded from zero in the same kind of pass;
// req_tready stays low until it ends. The calc state holds while the output
// register is full and not being read out; csr_ready is always high.
module mt19937_word_generator_core
   import mtwg_pkg::*;
#(
   parameter int unsigned STATE_WORDS  = STATE_WORDS_DEF,
   parameter int unsigned TWIST_OFFSET = TWIST_OFFSET_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] reseed, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] random_word
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int unsigned PosW = $clog2(STATE_WORDS);
   localparam logic [PosW-1:0] LastPos = PosW'(STATE_WORDS - 1);

   logic [31:0] mem [STATE_WORDS];

   mtwg_state_type state_ff, state_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [PosW-1:0] seed_idx_ff, seed_idx_in;
   logic [31:0]     prev_ff, prev_in;
   logic [31:0]     cache_ff, cache_in;      // current (untwisted) word k
   logic [31:0]     seed_ff, seed_in;
   logic            draw_pend_ff, draw_pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_data_ff, rsp_data_in;
   logic [31:0]     rd_a_ff, rd_b_ff;

   logic            req_xfer;
   logic            mem_we, mem_re;
   logic [PosW-1:0] mem_waddr;
   logic [31:0]     mem_wdata;
   logic [PosW-1:0] issue_pos, rd_addr_a, rd_addr_b;
   logic [PosW:0]   far_sum;
   logic [31:0]     seed_word, twisted;
   logic            out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // reads are issued for position 0 when leaving the seed pass
   assign issue_pos = (state_ff == ST_SEED) ? '0 : pos_ff;
   assign rd_addr_a = (issue_pos == LastPos) ? '0 : issue_pos + 1'b1;
   assign far_sum   = {1'b0, issue_pos} + (PosW+1)'(TWIST_OFFSET);
   assign rd_addr_b = (far_sum >= (PosW+1)'(STATE_WORDS))
                      ? PosW'(far_sum - (PosW+1)'(STATE_WORDS)) : PosW'(far_sum);

   assign seed_word = (seed_idx_ff == '0) ? seed_ff
                      : mtwg_seed_next(prev_ff, 32'(seed_idx_ff));
   assign twisted   = mtwg_twist(cache_ff, rd_a_ff, rd_b_ff);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      seed_idx_in  = seed_idx_ff;
      prev_in      = prev_ff;
      cache_in     = cache_ff;
      seed_in      = seed_ff;
      draw_pend_in = draw_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = seed_idx_ff;
      mem_wdata    = seed_word;

      if (csr_valid && csr_ready) begin
         seed_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_SEED: begin
            mem_we      = 1'b1;
            prev_in     = seed_word;
            seed_idx_in = seed_idx_ff + 1'b1;
            if (seed_idx_ff == '0) begin
               cache_in = seed_word;
            end
            if (seed_idx_ff == LastPos) begin
               pos_in = '0;
               if (draw_pend_ff) begin
                  mem_re   = 1'b1;
                  state_in = ST_CALC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tdata[0]) begin
                  seed_idx_in  = '0;
                  draw_pend_in = 1'b1;
                  state_in     = ST_SEED;
               end else begin
                  mem_re   = 1'b1;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            // hold until the output register can take the word
            if (out_free) begin
               mem_we       = 1'b1;
               mem_waddr    = pos_ff;
               mem_wdata    = twisted;
               cache_in     = rd_a_ff;
               pos_in       = (pos_ff == LastPos) ? '0 : pos_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = mtwg_temper(twisted);
               draw_pend_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEED;
         seed_idx_ff  <= '0;
         pos_ff       <= '0;
         seed_ff      <= '0;
         draw_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_idx_ff  <= seed_idx_in;
         pos_ff       <= pos_in;
         seed_ff      <= seed_in;
         draw_pend_ff <= draw_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      cache_ff    <= cache_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LastPos)
      else $error("word position out of range");

   a_reseed_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tdata[0] |=> state_ff == ST_SEED && seed_idx_ff == '0)
      else $error("reseed did not start at word 0");

   a_draw_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_tdata[0] |=> state_ff == ST_CALC)
      else $error("draw did not go to calc");

   a_calc_loads_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("calc cycle did not load the output register");

endmodule
